// ===== hw/rtl/aema_pkg.sv =====
// Shared constants, codes and types of the adaptive EMA light mode detector.
package aema_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int MV_W          = 12;
    localparam int MV_FULL_SCALE = 3300;
    localparam int FRAC_W        = 16;
    localparam int LEVEL_W       = MV_W + FRAC_W;
    localparam int ALPHA_W       = 16;
    localparam int THR_W         = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ALPHA_W-1:0] SLOW_WT_RST   = 16'd3277;
    localparam logic [ALPHA_W-1:0] FAST_WT_RST   = 16'd52429;
    localparam logic [THR_W-1:0]   DELTA_THR_RST = 12'd150;
    localparam logic [THR_W-1:0]   NIGHT_THR_RST = 12'd1000;
    localparam logic [THR_W-1:0]   DAY_THR_RST   = 12'd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOW_WT   = 3'd0,
        CFG_FAST_WT   = 3'd1,
        CFG_DELTA_THR = 3'd2,
        CFG_NIGHT_THR = 3'd3,
        CFG_DAY_THR   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [ALPHA_W-1:0] slow_wt;
        logic [ALPHA_W-1:0] fast_wt;
        logic [THR_W-1:0]   delta_thr;
        logic [THR_W-1:0]   night_thr;
        logic [THR_W-1:0]   day_thr;
    } t_cfg;

    typedef struct packed {
        logic [MV_W-1:0] sample_mv;
        logic [MV_W-1:0] smooth_mv;
        logic            is_night;
    } t_result;

endpackage

// ===== hw/rtl/aema_if.sv =====
// Channel interfaces: sample input, result output and configuration write.
interface aema_in_if #(
    parameter int SAMPLE_BITS = aema_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface aema_res_if;
    logic                      valid;
    logic                      ready;
    logic [aema_pkg::MV_W-1:0] sample_mv;
    logic [aema_pkg::MV_W-1:0] smooth_mv;
    logic                      is_night;

    modport source (output valid, output sample_mv, output smooth_mv, output is_night,
                    input ready);
    modport sink   (input valid, input sample_mv, input smooth_mv, input is_night,
                    output ready);
endinterface

interface aema_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [aema_pkg::CFG_IDX_W-1:0]  index;
    logic [aema_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/aema_front.sv =====
// Front stage: accept raw samples and scale them to millivolts.
module aema_front #(
    parameter int SAMPLE_BITS = aema_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [SAMPLE_BITS-1:0]    i_raw,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [aema_pkg::MV_W-1:0] o_mv
);
    // raw * 3300 fits in SAMPLE_BITS + 12 bits
    localparam int XW = SAMPLE_BITS + aema_pkg::MV_W;
    localparam logic [XW-1:0] FULL = XW'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic                      r_valid;
    logic [aema_pkg::MV_W-1:0] r_mv;
    logic [aema_pkg::MV_W-1:0] n_mv;
    logic [XW-1:0] prod, hi1, sum1, hi2, sum2, quot;

    // x / (2^n - 1): fold the high part onto the low part twice, the
    // remaining sum is below twice the divisor, so one compare finishes it
    always_comb begin
        prod = XW'(i_raw) * XW'(aema_pkg::MV_FULL_SCALE);
        hi1  = prod >> SAMPLE_BITS;
        sum1 = hi1 + (prod & FULL);
        hi2  = sum1 >> SAMPLE_BITS;
        sum2 = hi2 + (sum1 & FULL);
        quot = hi1 + hi2 + ((sum2 >= FULL) ? XW'(1) : XW'(0));
        n_mv = quot[aema_pkg::MV_W-1:0];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_mv    = r_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_mv <= n_mv;
        end
    end

endmodule

// ===== hw/rtl/aema_fifo.sv =====
// Short queue of millivolt values between the front and back stages.
module aema_fifo #(
    parameter int DEPTH = aema_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [aema_pkg::MV_W-1:0] i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [aema_pkg::MV_W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [aema_pkg::MV_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]             r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]             r_count;
    logic                      wr_en, rd_en;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != CW'(0));
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_valid && o_ready;
    assign rd_en   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/aema_back.sv =====
// Back stages: adaptive EMA update, then day/night hysteresis into the output register.
module aema_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  aema_pkg::t_cfg            i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [aema_pkg::MV_W-1:0] i_mv,
    output logic                      o_valid,
    input  logic                      i_ready,
    output aema_pkg::t_result         o_res
);
    localparam int MV_W    = aema_pkg::MV_W;
    localparam int FRAC_W  = aema_pkg::FRAC_W;
    localparam int LEVEL_W = aema_pkg::LEVEL_W;
    localparam int ALPHA_W = aema_pkg::ALPHA_W;
    localparam int PROD_W  = LEVEL_W + ALPHA_W + 2;
    localparam int STEP_W  = PROD_W - FRAC_W;

    // filter state
    logic               r_primed;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;
    // update stage
    logic               r_a_valid;
    logic [MV_W-1:0]    r_a_mv;
    logic [MV_W-1:0]    r_a_filt;
    // output stage
    logic               r_b_valid;
    logic               r_night;
    logic               n_night;
    aema_pkg::t_result  r_b_res;

    logic                      in_acc, a_ready, b_ready, b_load;
    logic [LEVEL_W-1:0]        sample_q, level_eff;
    logic [MV_W-1:0]           level_int, delta;
    logic [ALPHA_W-1:0]        alpha;
    logic signed [LEVEL_W:0]   diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [STEP_W-1:0]  sum_full;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign b_load  = r_a_valid && b_ready;
    assign in_acc  = i_valid && a_ready;
    assign o_ready = a_ready;

    // F' = F + floor(alpha * (S - F) / 2^16), identical to the weighted sum
    always_comb begin
        sample_q  = {i_mv, {FRAC_W{1'b0}}};
        level_eff = r_primed ? r_level : sample_q;
        level_int = level_eff[LEVEL_W-1:FRAC_W];
        delta     = (i_mv >= level_int) ? (i_mv - level_int) : (level_int - i_mv);
        alpha     = (delta > i_cfg.delta_thr) ? i_cfg.fast_wt : i_cfg.slow_wt;
        diff      = $signed({1'b0, sample_q}) - $signed({1'b0, level_eff});
        prod      = $signed({1'b0, alpha}) * diff;
        sum_full  = $signed({2'b00, level_eff}) + $signed(prod[PROD_W-1:FRAC_W]);
        n_level   = sum_full[LEVEL_W-1:0];
    end

    // only the condition of the current mode is tested
    always_comb begin
        if (r_night) begin
            n_night = !(r_a_filt > i_cfg.day_thr);
        end else begin
            n_night = (r_a_filt < i_cfg.night_thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed  <= 1'b0;
            r_night   <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_primed <= 1'b1;
            end
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (b_load) begin
                r_night <= n_night;
            end
        end
        if (in_acc) begin
            r_level  <= n_level;
            r_a_mv   <= i_mv;
            r_a_filt <= n_level[LEVEL_W-1:FRAC_W];
        end
        if (b_load) begin
            r_b_res.sample_mv <= r_a_mv;
            r_b_res.smooth_mv <= r_a_filt;
            r_b_res.is_night  <= n_night;
        end
    end

    assign o_valid = r_b_valid;
    assign o_res   = r_b_res;

    a_primed_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_primed)
        else $error("filter not primed after a sample");

    a_level_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed && !in_acc |=> $stable(r_level))
        else $error("filter level moved without a sample");

    a_mode_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !b_load |=> $stable(r_night))
        else $error("mode changed without a result");

    a_update_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !b_ready |=> r_a_valid && $stable(r_a_filt) && $stable(r_a_mv))
        else $error("update stage lost or changed its item under stall");

    a_result_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_load |=> (o_res.is_night == r_night))
        else $error("result mode differs from held mode");

endmodule

// ===== hw/rtl/adaptive_ema_light_mode_detector.sv =====
// Top level of the adaptive EMA light mode detector: config registers and stage wiring.
//
// Usage:
//   i_in  : one raw light sensor sample per transaction (raw_sample, low SAMPLE_BITS bits).
//   o_res : one result per sample, in order: sample_mv (raw * 3300 / (2^SAMPLE_BITS - 1),
//           truncated), smooth_mv (integer part of the 12.16 EMA level) and is_night.
//   i_cfg : register writes by index (0 slow weight, 1 fast weight, 2 delta threshold,
//           3 night threshold, 4 day threshold); always ready, other indexes are dropped.
//           Write only while no sample is in flight.
// Timing:
//   From the input transaction to the output transaction a sample passes, in order, the
//   millivolt scaling register, queue, EMA update register, hysteresis/output register.
//   Throughput is one sample per cycle while o_res.ready is high; the EMA update (one
//   17x29 multiply and add) closes on itself in r_level, as does the day/night mode register.
// Reset (i_rst_n low, synchronous): registers return to their defaults, the filter is
//   unprimed (the next sample seeds it) and the mode is day. Nothing is in flight.
// Stall: when o_res.ready is low the output register holds, the update stage holds,
//   and the QUEUE_DEPTH-entry queue (2 by default) plus the front register absorb further
//   samples before i_in.ready drops.
module adaptive_ema_light_mode_detector #(
    parameter int SAMPLE_BITS = aema_pkg::SAMPLE_BITS_DEF,
    parameter int QUEUE_DEPTH = aema_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aema_in_if.sink     i_in,
    aema_res_if.source  o_res,
    aema_cfg_if.sink    i_cfg
);
    aema_pkg::t_cfg            r_cfg;
    aema_pkg::t_result         back_res;
    logic                      front_valid, front_ready;
    logic [aema_pkg::MV_W-1:0] front_mv;
    logic                      queue_valid, queue_ready;
    logic [aema_pkg::MV_W-1:0] queue_mv;
    logic                      cfg_wr;

    // configuration: always take the write, mask the data to the register width
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_wt   <= aema_pkg::SLOW_WT_RST;
            r_cfg.fast_wt   <= aema_pkg::FAST_WT_RST;
            r_cfg.delta_thr <= aema_pkg::DELTA_THR_RST;
            r_cfg.night_thr <= aema_pkg::NIGHT_THR_RST;
            r_cfg.day_thr   <= aema_pkg::DAY_THR_RST;
        end else if (cfg_wr) begin
            case (aema_pkg::t_cfg_idx'(i_cfg.index))
                aema_pkg::CFG_SLOW_WT: begin
                    r_cfg.slow_wt <= i_cfg.data[aema_pkg::ALPHA_W-1:0];
                end
                aema_pkg::CFG_FAST_WT: begin
                    r_cfg.fast_wt <= i_cfg.data[aema_pkg::ALPHA_W-1:0];
                end
                aema_pkg::CFG_DELTA_THR: begin
                    r_cfg.delta_thr <= i_cfg.data[aema_pkg::THR_W-1:0];
                end
                aema_pkg::CFG_NIGHT_THR: begin
                    r_cfg.night_thr <= i_cfg.data[aema_pkg::THR_W-1:0];
                end
                aema_pkg::CFG_DAY_THR: begin
                    r_cfg.day_thr <= i_cfg.data[aema_pkg::THR_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // front: scale to millivolts
    aema_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_raw   (i_in.raw_sample),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_mv    (front_mv)
    );

    // queue: decouple the front from a stalled back end
    aema_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_mv),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_data  (queue_mv)
    );

    // back: filter update and day/night decision
    aema_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (queue_valid),
        .o_ready (queue_ready),
        .i_mv    (queue_mv),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (back_res)
    );

    assign o_res.sample_mv = back_res.sample_mv;
    assign o_res.smooth_mv = back_res.smooth_mv;
    assign o_res.is_night  = back_res.is_night;

endmodule
